// ----- rtl/core/mppd_pkg.sv -----
package mppd_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 34;
    localparam int ROOT_W  = 17;
    localparam int SEL_W   = 2;

    // Metric codes; the unused code behaves as Chebyshev.
    localparam logic [SEL_W-1:0] METRIC_EUCL = 2'd0;
    localparam logic [SEL_W-1:0] METRIC_MANH = 2'd1;
    localparam logic [SEL_W-1:0] METRIC_CHEB = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]         t_dist;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // One pair comparison request into the metric pipeline.
    typedef struct packed {
        logic             vld;
        logic [SEL_W-1:0] sel;
        t_point           query;
        t_point           stored;
    } t_pair_req;

    typedef struct packed {
        logic  vld;
        t_dist dist_val;
    } t_pair_res;

endpackage

// ----- rtl/core/mppd_cell.sv -----
module mppd_cell
    import mppd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_point i_point,
    output t_point o_point
);

    t_point r_point;

    // Take the neighbor's point on every shift cycle.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_point <= i_point;
        end
    end

    assign o_point = r_point;

endmodule

// ----- rtl/core/mppd_metric.sv -----
module mppd_metric
    import mppd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pair_req i_req,
    output t_pair_res o_res
);

    logic signed [COORD_W:0] w_dx_s;
    logic signed [COORD_W:0] w_dy_s;
    logic [COORD_W:0]        w_dx_a;
    logic [COORD_W:0]        w_dy_a;

    logic                   r_va;
    logic [SEL_W-1:0]       r_sel_a;
    logic [COORD_W-1:0]     r_dx;
    logic [COORD_W-1:0]     r_dy;

    logic                   r_vb;
    logic [SEL_W-1:0]       r_sel_b;
    logic [2*COORD_W-1:0]   r_sqx;
    logic [2*COORD_W-1:0]   r_sqy;
    logic [COORD_W:0]       r_l1;
    logic [COORD_W-1:0]     r_linf;

    assign w_dx_s = {i_req.query.x[COORD_W-1], i_req.query.x}
                  - {i_req.stored.x[COORD_W-1], i_req.stored.x};
    assign w_dy_s = {i_req.query.y[COORD_W-1], i_req.query.y}
                  - {i_req.stored.y[COORD_W-1], i_req.stored.y};
    assign w_dx_a = w_dx_s[COORD_W] ? 17'(-w_dx_s) : 17'(w_dx_s);
    assign w_dy_a = w_dy_s[COORD_W] ? 17'(-w_dy_s) : 17'(w_dy_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_req.vld;
            r_vb <= r_va;
        end
        // magnitude of a 16-bit difference fits in 16 bits
        r_sel_a <= i_req.sel;
        r_dx    <= w_dx_a[COORD_W-1:0];
        r_dy    <= w_dy_a[COORD_W-1:0];
        r_sel_b <= r_sel_a;
        r_sqx   <= r_dx * r_dx;
        r_sqy   <= r_dy * r_dy;
        r_l1    <= {1'b0, r_dx} + {1'b0, r_dy};
        r_linf  <= (r_dx > r_dy) ? r_dx : r_dy;
    end

    always_comb begin
        o_res.vld = r_vb;
        unique case (r_sel_b)
            METRIC_EUCL: o_res.dist_val = DIST_W'({1'b0, r_sqx} + {1'b0, r_sqy});
            METRIC_MANH: o_res.dist_val = DIST_W'(r_l1);
            default:     o_res.dist_val = DIST_W'(r_linf);
        endcase
    end

endmodule

// ----- rtl/core/mppd_isqrt.sv -----
module mppd_isqrt
    import mppd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_dist             i_op,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam t_dist BIT_TOP = t_dist'(1) << (2 * (ROOT_W - 1));

    logic              r_busy;
    logic              r_done;
    t_dist             r_v;
    t_dist             r_res;
    t_dist             r_bit;
    logic [DIST_W:0]   w_trial;
    logic              w_take;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = {1'b0, r_v} >= w_trial;

    // One result bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_op;
                r_res  <= '0;
                r_bit  <= BIT_TOP;
            end else if (r_busy) begin
                if (w_take) begin
                    r_v   <= DIST_W'({1'b0, r_v} - w_trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ----- rtl/core/max_pairwise_point_distance_top.sv -----
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------------
// points   | in        | i_s_tvalid / o_s_tready  | i_s_tdata: point_x, point_y; i_s_tlast
// result   | out       | o_m_tvalid / i_m_tready  | o_m_tdata: max_distance, overflow
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_data: metric_select
//
// For a stored point, the point ring rotates once past the metric pipeline (one stored
// point per cycle), then the two pipeline stages drain. A last point then passes
// finish and emit, with the square root between them under Euclidean. A point beyond
// the store is dropped and flags overflow; if it closes the set, finish follows.
// One point is in work at a time.
// Reset (synchronous, active low) clears count, best distance, flags and metric.
// A result held at the output does not stop the next point; only the next result waits.
module max_pairwise_point_distance_top
    import mppd_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // point request
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // [15:0] point_x, [31:16] point_y
    input  logic             i_s_tlast,   // last_point
    // result request
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,   // [16:0] max_distance, [17] overflow, zero fill
    // configuration write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [SEL_W-1:0] i_cfg_data   // metric_select
);

    localparam int KW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_POINTS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_POINTS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_ROOT, S_EMIT
    } t_state;

    t_state            r_state;
    logic [SEL_W-1:0]  r_metric;
    logic [SEL_W-1:0]  r_sel;
    t_point            r_query;
    logic              r_last;
    logic [CW-1:0]     r_count;
    logic [KW-1:0]     r_k;
    t_dist             r_best;
    logic              r_dropped;
    logic [ROOT_W-1:0] r_result;
    logic              r_m_tvalid;
    logic [ROOT_W-1:0] r_out_dist;
    logic              r_out_ovf;
    logic [1:0]        r_drain_cnt;

    t_point            w_cell [MAX_POINTS];
    t_point            n_tail;
    logic              w_shift;
    logic              w_accept;
    logic              w_load;
    logic              w_pipe_busy;
    t_pair_req         w_req;
    t_pair_res         w_res;
    logic              w_root_start;
    logic              w_root_done;
    logic [ROOT_W-1:0] w_root;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_shift  = (r_state == S_SCAN);
    assign w_load   = (r_state == S_EMIT) && (!r_m_tvalid || i_m_tready);

    // The head cell holds stored entry k on scan step k; write the new point
    // back into the ring where entry count passes the tail.
    assign n_tail = (CW'(r_k) == r_count) ? r_query : w_cell[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++) begin : g_ring
            mppd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_point ((gi == MAX_POINTS - 1) ? n_tail : w_cell[(gi + 1) % MAX_POINTS]),
                .o_point (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        w_req.vld    = w_shift && (CW'(r_k) < r_count);
        w_req.sel    = r_sel;
        w_req.query  = r_query;
        w_req.stored = w_cell[0];
    end

    mppd_metric u_metric (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    assign w_root_start = (r_state == S_FINISH) && (r_sel == METRIC_EUCL);

    mppd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_op    (r_best),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_metric   <= METRIC_EUCL;
            r_count    <= '0;
            r_k        <= '0;
            r_best     <= '0;
            r_dropped  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_metric <= i_cfg_data;
            end
            // load a new result or drop the one just taken
            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            // fold each finished pair into the running maximum
            if (w_res.vld && (w_res.dist_val > r_best)) begin
                r_best <= w_res.dist_val;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_query <= '{x: i_s_tdata[15:0], y: i_s_tdata[31:16]};
                        r_last  <= i_s_tlast;
                        r_sel   <= r_metric;
                        r_k     <= '0;
                        if (r_count < CNT_FULL) begin
                            r_state <= S_SCAN;
                        end else begin
                            // store full: drop the point
                            r_dropped <= 1'b1;
                            if (i_s_tlast) begin
                                r_state <= S_FINISH;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!w_req.vld && !w_res.vld && !w_pipe_busy) begin
                        r_state <= r_last ? S_FINISH : S_IDLE;
                    end
                end
                S_FINISH: begin
                    r_result <= r_best[ROOT_W-1:0];
                    r_state  <= (r_sel == METRIC_EUCL) ? S_ROOT : S_EMIT;
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_result <= w_root;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_dist <= r_result;
                        r_out_ovf  <= r_dropped;
                        r_count    <= '0;
                        r_best     <= '0;
                        r_dropped  <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Drain tracking: the first pipeline stage still holds the last scan request when drain
    // begins, so stay in drain until the counter shows both pipeline stages have emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_cnt <= '0;
        end else if (r_state == S_DRAIN) begin
            r_drain_cnt <= r_drain_cnt + 1'b1;
        end else begin
            r_drain_cnt <= '0;
        end
    end

    assign w_pipe_busy = (r_drain_cnt < 2'd2);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = {6'b0, r_out_ovf, r_out_dist};

    // Point count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("point count beyond store depth");

    // Pair results only arrive while a scan is in flight.
    a_res_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("pair result outside scan");

    // Root completes only while waiting for it.
    a_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == S_ROOT))
        else $error("square root done in wrong state");

    // Issuing a result clears the set.
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_count == '0 && r_best == '0 && !r_dropped && r_m_tvalid))
        else $error("set state not cleared after result");

endmodule
